[hw/rtl/mroe_pkg.sv]
// Shared types and constants for the matrix row operation engine.
package mroe_pkg;

  localparam int unsigned MAX_DIM   = 64;
  localparam int unsigned DIM_W     = $clog2(MAX_DIM);
  localparam int unsigned CNT_W     = DIM_W + 1;
  localparam int unsigned ADDR_W    = 2 * DIM_W;
  localparam int unsigned MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned FIELD_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd3;
  localparam logic [OP_W-1:0] OP_NEG   = 3'd4;
  localparam logic [OP_W-1:0] OP_SWAP  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [FIELD_W-1:0]       row_a;
    logic [FIELD_W-1:0]       row_b;
    logic [FIELD_W-1:0]       column;
    logic signed [DATA_W-1:0] multiplier;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     status;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             wr_elem;
    logic             rd_elem;
    logic             issue;
    logic [DIM_W-1:0] col;
    logic             fin;
    logic             fin_read;
    logic             fin_status;
  } cmd_t;

endpackage

[hw/rtl/mroe_dpath.sv]
// Datapath: matrix store, column pipeline with multiplier, result register.
module mroe_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mroe_pkg::cmd_t       cmd_i,
  input  mroe_pkg::in_item_t   in_data_i,
  output mroe_pkg::out_item_t  out_data_o
);

  logic [mroe_pkg::DATA_W-1:0]  mem_q [mroe_pkg::MEM_DEPTH];

  logic [mroe_pkg::OP_W-1:0]    op_q;
  logic [mroe_pkg::DIM_W-1:0]   ra_q;
  logic [mroe_pkg::DIM_W-1:0]   rb_q;
  logic [mroe_pkg::DIM_W-1:0]   ecol_q;
  logic [mroe_pkg::DATA_W-1:0]  mul_q;
  logic [mroe_pkg::DATA_W-1:0]  val_q;

  logic [mroe_pkg::DATA_W-1:0]  rda_q;
  logic [mroe_pkg::DATA_W-1:0]  rdb_q;
  logic [mroe_pkg::DATA_W-1:0]  a_q;
  logic [mroe_pkg::DATA_W-1:0]  b_q;
  logic [mroe_pkg::DATA_W-1:0]  prod_q;
  logic [mroe_pkg::DATA_W-1:0]  s3_a_q;
  logic                         s1_vld_q;
  logic                         s2_vld_q;
  logic                         s3_vld_q;
  logic [mroe_pkg::DIM_W-1:0]   s1_col_q;
  logic [mroe_pkg::DIM_W-1:0]   s2_col_q;
  logic [mroe_pkg::DIM_W-1:0]   s3_col_q;
  mroe_pkg::out_item_t          out_q;

  logic                         rd_en;
  logic [mroe_pkg::ADDR_W-1:0]  rd_addr_a;
  logic [mroe_pkg::ADDR_W-1:0]  rd_addr_b;
  logic [mroe_pkg::DATA_W-1:0]  prod_lo;
  logic                         we;
  logic [mroe_pkg::ADDR_W-1:0]  wr_addr;
  logic [mroe_pkg::DATA_W-1:0]  wr_data;
  logic [mroe_pkg::DATA_W-1:0]  row_res;

  assign rd_en     = cmd_i.rd_elem | cmd_i.issue;
  assign rd_addr_a = cmd_i.rd_elem ? {ra_q, ecol_q} : {ra_q, cmd_i.col};
  assign rd_addr_b = {rb_q, cmd_i.col};
  assign prod_lo   = rdb_q * mul_q;

  always_comb begin
    case (op_q)
      mroe_pkg::OP_ADD:  row_res = a_q + prod_q;
      mroe_pkg::OP_SUB:  row_res = a_q - prod_q;
      mroe_pkg::OP_NEG:  row_res = '0 - a_q;
      mroe_pkg::OP_SWAP: row_res = b_q;
      default:           row_res = a_q;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = {ra_q, ecol_q};
    wr_data = val_q;
    if (cmd_i.wr_elem) begin
      we = 1'b1;
    end else if (s2_vld_q) begin
      we      = 1'b1;
      wr_addr = {ra_q, s2_col_q};
      wr_data = row_res;
    end else if (s3_vld_q) begin
      we      = 1'b1;
      wr_addr = {rb_q, s3_col_q};
      wr_data = s3_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rda_q <= mem_q[rd_addr_a];
      rdb_q <= mem_q[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i.operation;
      ra_q   <= in_data_i.row_a;
      rb_q   <= in_data_i.row_b;
      ecol_q <= in_data_i.column;
      mul_q  <= in_data_i.multiplier;
      val_q  <= in_data_i.element_value;
    end
    s1_col_q <= cmd_i.col;
    s2_col_q <= s1_col_q;
    s3_col_q <= s2_col_q;
    a_q      <= rda_q;
    b_q      <= rdb_q;
    prod_q   <= prod_lo;
    s3_a_q   <= a_q;
    if (cmd_i.fin) begin
      out_q.read_value <= cmd_i.fin_read ? rda_q : '0;
      out_q.status     <= cmd_i.fin_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q && (op_q == mroe_pkg::OP_SWAP);
    end
  end

  assign out_data_o = out_q;

endmodule

[hw/rtl/mroe_ctrl.sv]
// Controller: size registers, index checks and operation sequencer.
module mroe_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mroe_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mroe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mroe_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output mroe_pkg::cmd_t                 cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_ROW,
    S_SWAP_RD,
    S_SWAP_GAP,
    S_DRAIN,
    S_FINISH
  } state_e;

  localparam logic [mroe_pkg::CNT_W-1:0] DIM_MAX = mroe_pkg::CNT_W'(mroe_pkg::MAX_DIM);
  localparam logic [1:0]                 DRAIN_LEN = 2'd1;

  state_e                        state_q, state_d;
  logic [mroe_pkg::CNT_W-1:0]    row_cnt_q, row_cnt_d;
  logic [mroe_pkg::CNT_W-1:0]    col_cnt_q, col_cnt_d;
  logic [mroe_pkg::DIM_W-1:0]    col_q, col_d;
  logic [1:0]                    drain_q, drain_d;
  logic                          fin_read_q, fin_read_d;
  logic                          fin_status_q, fin_status_d;
  logic                          out_valid_q, out_valid_d;

  logic [mroe_pkg::CNT_W-1:0]    nr;
  logic [mroe_pkg::CNT_W-1:0]    nc;
  logic [mroe_pkg::CNT_W-1:0]    nc_m1;
  logic                          last_col;
  logic                          ra_ok;
  logic                          rb_ok;
  logic                          col_ok;
  logic                          err;

  assign nr       = (row_cnt_q > DIM_MAX) ? DIM_MAX : row_cnt_q;
  assign nc       = (col_cnt_q > DIM_MAX) ? DIM_MAX : col_cnt_q;
  assign nc_m1    = nc - mroe_pkg::CNT_W'(1);
  assign last_col = (col_q == nc_m1[mroe_pkg::DIM_W-1:0]);
  assign ra_ok    = ({1'b0, in_data_i.row_a} < nr);
  assign rb_ok    = ({1'b0, in_data_i.row_b} < nr);
  assign col_ok   = ({1'b0, in_data_i.column} < nc);

  always_comb begin
    err = 1'b1;
    if ((nr != '0) && (nc != '0) && ra_ok) begin
      case (in_data_i.operation)
        mroe_pkg::OP_WRITE: err = !col_ok;
        mroe_pkg::OP_READ:  err = !col_ok;
        mroe_pkg::OP_ADD:   err = !rb_ok;
        mroe_pkg::OP_SUB:   err = !rb_ok;
        mroe_pkg::OP_NEG:   err = 1'b0;
        mroe_pkg::OP_SWAP:  err = !rb_ok;
        default:            err = 1'b1;
      endcase
    end
  end

  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mroe_pkg::CFG_ROW_COUNT:    row_cnt_d = cfg_data_i;
        mroe_pkg::CFG_COLUMN_COUNT: col_cnt_d = cfg_data_i;
        default:                    ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    drain_d      = drain_q;
    fin_read_d   = fin_read_q;
    fin_status_d = fin_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.col    = col_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load   = 1'b1;
          col_d        = '0;
          fin_status_d = err;
          fin_read_d   = 1'b0;
          if (err) begin
            state_d = S_FINISH;
          end else begin
            case (in_data_i.operation)
              mroe_pkg::OP_WRITE: state_d = S_WRITE;
              mroe_pkg::OP_READ: begin
                state_d    = S_READ;
                fin_read_d = 1'b1;
              end
              mroe_pkg::OP_SWAP:  state_d = S_SWAP_RD;
              default:            state_d = S_ROW;
            endcase
          end
        end
      end
      S_WRITE: begin
        cmd_o.wr_elem = 1'b1;
        state_d       = S_FINISH;
      end
      S_READ: begin
        cmd_o.rd_elem = 1'b1;
        state_d       = S_FINISH;
      end
      S_ROW: begin
        cmd_o.issue = 1'b1;
        if (last_col) begin
          drain_d = DRAIN_LEN;
          state_d = S_DRAIN;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      S_SWAP_RD: begin
        cmd_o.issue = 1'b1;
        state_d     = S_SWAP_GAP;
      end
      S_SWAP_GAP: begin
        if (last_col) begin
          drain_d = DRAIN_LEN;
          state_d = S_DRAIN;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = S_SWAP_RD;
        end
      end
      S_DRAIN: begin
        if (drain_q == '0) begin
          state_d = S_FINISH;
        end else begin
          drain_d = drain_q - 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_read   = fin_read_q;
          cmd_o.fin_status = fin_status_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      row_cnt_q    <= '0;
      col_cnt_q    <= '0;
      col_q        <= '0;
      drain_q      <= '0;
      fin_read_q   <= 1'b0;
      fin_status_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_cnt_q    <= row_cnt_d;
      col_cnt_q    <= col_cnt_d;
      col_q        <= col_d;
      drain_q      <= drain_d;
      fin_read_q   <= fin_read_d;
      fin_status_q <= fin_status_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/matrix_row_operation_engine_core.sv]
// Index errors go straight to the result; element write and read make a single store access;
// add, subtract and negate stream one column a cycle through the multiplier; swap issues
// one column at a time, as the single store write port takes two writes per column.
// Throughput: one item at a time, accepted in the cycle its predecessor's result turns valid;
// that result may still wait for out_ready.
// Reset clears the size registers to zero and all control state; the store is not cleared.
module matrix_row_operation_engine_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mroe_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mroe_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mroe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mroe_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  mroe_pkg::cmd_t cmd;

  mroe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd)
  );

  mroe_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
